// ===== design/sstx_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the seven-segment text scanner.
// No dependencies; the scanner top, sequencer and datapath import this package.
package sstx_pkg;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_FONT   = 2'd3;

   localparam logic REG_DISPLAY_TYPE = 1'b0;
   localparam logic REG_DIGIT_COUNT  = 1'b1;

   localparam logic [20:0] CODE_QMARK = 21'h00003F;
   localparam logic [20:0] CODE_DOT   = 21'h00002E;
   localparam logic [20:0] CODE_DASH  = 21'h00002D;
   localparam logic [6:0]  GLYPH_BLANK = 7'b0000000;
   localparam logic [5:0]  VISIBLE_MAX = 6'd63;
   localparam logic [3:0]  DIGIT_COUNT_RESET = 4'd8;

   typedef enum logic [1:0] {
      STATUS_NORMAL = 2'd0,
      STATUS_DASHES = 2'd1,
      STATUS_QMARK  = 2'd2,
      STATUS_BLANK  = 2'd3
   } status_type;

   typedef struct packed {
      logic load;
      logic append;
      logic clear;
      logic font_wr;
      logic fill_clr;
      logic fill;
      logic norm;
      logic rd_next;
      logic skip;
      logic cap_ch;
      logic cap_dp;
      logic srch_step;
      logic srch_eval;
      logic emit;
      logic emit_tick;
   } dp_cmd_type;

   typedef struct packed {
      logic tlen_zero;
      logic need_dashes;
      logic fill_last;
      logic srch_done;
   } dp_sts_type;

endpackage

// ===== design/seven_segment_text_scanner.sv =====
`timescale 1ns / 1ps
// Top level of the seven-segment text scanner: sequencer plus datapath.
// Depends on sstx_pkg, sstx_ctrl and sstx_dpath.
//
// One item is taken when start is high and busy is low; its single result
// appears for one cycle with rsp_valid, and cannot be held off. An append
// replaces a too-long text with dashes before the result beat. A scan tick
// searches the font slots in order from slot 0; the font search walks one
// slot per cycle through the font table's single read port. A tick on an
// empty text skips the read and the search. busy stays high until the
// result beat.
module seven_segment_text_scanner #(
   parameter int MAX_DIGIT_COUNT = 8,
   parameter int TEXT_DEPTH      = 32,
   parameter int FONT_DEPTH      = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [20:0] req_char_code,
   input  logic        req_end_of_text,
   input  logic [6:0]  req_font_index,
   input  logic [6:0]  req_glyph_bits,
   output logic        rsp_valid,
   output logic [7:0]  rsp_digit_lines,
   output logic [7:0]  rsp_segment_lines,
   output logic [1:0]  rsp_status,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [3:0]  csr_wdata
);
   import sstx_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   sstx_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .cmd           (cmd),
      .sts           (sts)
   );

   sstx_dpath #(
      .MAX_DIGIT_COUNT (MAX_DIGIT_COUNT),
      .TEXT_DEPTH      (TEXT_DEPTH),
      .FONT_DEPTH      (FONT_DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_char_code     (req_char_code),
      .req_end_of_text   (req_end_of_text),
      .req_font_index    (req_font_index),
      .req_glyph_bits    (req_glyph_bits),
      .rsp_digit_lines   (rsp_digit_lines),
      .rsp_segment_lines (rsp_segment_lines),
      .rsp_status        (rsp_status)
   );

endmodule

// ===== design/sstx_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the seven-segment text scanner.
// Depends on sstx_pkg; drives the datapath through dp_cmd_type.
module sstx_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_operation,
   output logic                   busy,
   output logic                   rsp_valid,
   output sstx_pkg::dp_cmd_type   cmd,
   input  sstx_pkg::dp_sts_type   sts
);
   import sstx_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_APPEND,
      S_ENDCHK,
      S_FILL,
      S_CLEAR,
      S_FONT,
      S_TK_NORM,
      S_TK_RD0,
      S_TK_SKIP,
      S_TK_RD1,
      S_TK_RD2,
      S_TK_DP,
      S_TK_SRCH,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      res_tick_ff, res_tick_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      res_tick_in  = res_tick_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load    = 1'b1;
               res_tick_in = 1'b0;
               case (req_operation)
                  OP_TICK:   state_in = S_TK_NORM;
                  OP_APPEND: state_in = S_APPEND;
                  OP_CLEAR:  state_in = S_CLEAR;
                  OP_FONT:   state_in = S_FONT;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_APPEND: begin
            cmd.append = 1'b1;
            state_in   = S_ENDCHK;
         end
         S_ENDCHK: begin
            cmd.fill_clr = 1'b1;
            state_in     = sts.need_dashes ? S_FILL : S_EMIT;
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            if (sts.fill_last) begin
               state_in = S_EMIT;
            end
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = S_EMIT;
         end
         S_FONT: begin
            cmd.font_wr = 1'b1;
            state_in    = S_EMIT;
         end
         S_TK_NORM: begin
            if (sts.tlen_zero) begin
               state_in = S_EMIT;
            end else begin
               cmd.norm = 1'b1;
               state_in = S_TK_RD0;
            end
         end
         S_TK_RD0: begin
            state_in = S_TK_SKIP;
         end
         S_TK_SKIP: begin
            cmd.skip = 1'b1;
            state_in = S_TK_RD1;
         end
         S_TK_RD1: begin
            state_in = S_TK_RD2;
         end
         S_TK_RD2: begin
            cmd.rd_next = 1'b1;
            cmd.cap_ch  = 1'b1;
            state_in    = S_TK_DP;
         end
         S_TK_DP: begin
            cmd.cap_dp    = 1'b1;
            cmd.srch_step = 1'b1;
            state_in      = S_TK_SRCH;
         end
         S_TK_SRCH: begin
            cmd.srch_eval = 1'b1;
            cmd.srch_step = 1'b1;
            if (sts.srch_done) begin
               res_tick_in = 1'b1;
               state_in    = S_EMIT;
            end
         end
         S_EMIT: begin
            cmd.emit      = 1'b1;
            cmd.emit_tick = res_tick_ff;
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         res_tick_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_tick_ff  <= res_tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/sstx_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: config registers, text store, font tables, search and result.
// Depends on sstx_pkg; sequenced by sstx_ctrl.
module sstx_dpath #(
   parameter int MAX_DIGIT_COUNT = 8,
   parameter int TEXT_DEPTH      = 32,
   parameter int FONT_DEPTH      = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sstx_pkg::dp_cmd_type   cmd,
   output sstx_pkg::dp_sts_type   sts,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [3:0]             csr_wdata,
   input  logic [20:0]            req_char_code,
   input  logic                   req_end_of_text,
   input  logic [6:0]             req_font_index,
   input  logic [6:0]             req_glyph_bits,
   output logic [7:0]             rsp_digit_lines,
   output logic [7:0]             rsp_segment_lines,
   output logic [1:0]             rsp_status
);
   import sstx_pkg::*;

   localparam int TAW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
   localparam int TLW = $clog2(TEXT_DEPTH + 1);
   localparam int RPW = $clog2(TEXT_DEPTH + 2);
   localparam int FAW = (FONT_DEPTH > 1) ? $clog2(FONT_DEPTH) : 1;
   localparam int DCW = $clog2(MAX_DIGIT_COUNT + 1);

   // config
   logic [1:0]  dtype_ff, dtype_in;
   logic [3:0]  dcnt_ff, dcnt_in;

   // latched item
   logic [20:0] code_ff, code_in;
   logic        last_ff, last_in;
   logic [6:0]  fidx_ff, fidx_in;
   logic [6:0]  glyph_ff, glyph_in;

   // text state
   logic [20:0] text_mem [TEXT_DEPTH];
   logic [20:0] text_q_ff;
   logic [TLW-1:0] tlen_ff, tlen_in;
   logic [5:0]  vis_ff, vis_in;
   logic [RPW-1:0] rp_ff, rp_in;
   logic [3:0]  sp_ff, sp_in;
   logic        tlong_ff, tlong_in;
   logic [TLW-1:0] fill_cnt_ff, fill_cnt_in;

   // tick working registers
   logic [20:0] ch_ff, ch_in;
   logic        dp_ff, dp_in;

   // font
   logic [20:0] font_code_mem [FONT_DEPTH];
   logic [6:0]  font_glyph_mem [FONT_DEPTH];
   logic [FONT_DEPTH-1:0] font_vld_ff, font_vld_in;
   logic [20:0] font_code_q_ff;
   logic [6:0]  font_glyph_q_ff;
   logic        font_vld_q_ff;
   logic [FAW-1:0] srch_idx_ff, srch_idx_in;
   logic [FAW-1:0] eval_idx_ff;
   logic        found_ff, found_in;
   logic        qfound_ff, qfound_in;
   logic [6:0]  bitmap_ff, bitmap_in;
   logic [6:0]  qbitmap_ff, qbitmap_in;

   // result
   logic [7:0]  dl_ff, dl_in;
   logic [7:0]  sl_ff, sl_in;
   status_type  st_ff, st_in;

   logic [DCW-1:0] dc;
   logic [TLW-1:0] fill_n;
   logic           room;
   logic           char_ok, next_ok;
   logic [RPW:0]   rp_next;
   logic [TAW-1:0] text_raddr, text_waddr;
   logic           text_we;
   logic [20:0]    text_wdata;
   logic           font_we;
   logic [FAW-1:0] font_waddr;
   logic [20:0]    f_code;
   logic signed [7:0] pos;
   logic           dig_on;
   logic           son, don;
   logic [6:0]     bm_sel;

   always_comb begin
      if (dcnt_ff == 4'd0) begin
         dc = DCW'(1);
      end else if (int'(dcnt_ff) > MAX_DIGIT_COUNT) begin
         dc = DCW'(MAX_DIGIT_COUNT);
      end else begin
         dc = DCW'(dcnt_ff);
      end
      if (int'(dc) > TEXT_DEPTH) begin
         fill_n = TLW'(TEXT_DEPTH);
      end else begin
         fill_n = TLW'(dc);
      end
   end

   assign room       = int'(tlen_ff) < TEXT_DEPTH;
   assign rp_next    = {1'b0, rp_ff} + (RPW+1)'(1);
   assign char_ok    = int'(rp_ff) < int'(tlen_ff);
   assign next_ok    = int'(rp_next) < int'(tlen_ff);
   assign text_raddr = cmd.rd_next ? TAW'(rp_next) : TAW'(rp_ff);
   assign text_we    = (cmd.append && (code_ff != 21'd0) && room) || cmd.fill;
   assign text_waddr = cmd.fill ? TAW'(fill_cnt_ff) : TAW'(tlen_ff);
   assign text_wdata = cmd.fill ? CODE_DASH : code_ff;
   assign font_we    = cmd.font_wr && (int'(fidx_ff) < FONT_DEPTH);
   assign font_waddr = FAW'(fidx_ff);
   assign f_code     = font_vld_q_ff ? font_code_q_ff : 21'd0;

   assign sts.tlen_zero   = (tlen_ff == '0);
   assign sts.need_dashes = last_ff && (int'(vis_ff) > int'(dc));
   assign sts.fill_last   = (int'(fill_cnt_ff) + 1) == int'(fill_n);
   assign sts.srch_done   = (f_code == 21'd0) || (f_code == ch_ff) ||
                            (int'(eval_idx_ff) == FONT_DEPTH - 1);

   assign son    = dtype_ff[0];
   assign don    = ~(dtype_ff[1] ^ dtype_ff[0]);
   assign pos    = 8'(sp_ff) + 8'(dc) - 8'(vis_ff);
   assign dig_on = !pos[7] && (pos < 8'(dc)) && (pos < 8'sd8);
   assign bm_sel = found_ff ? bitmap_ff : (qfound_ff ? qbitmap_ff : GLYPH_BLANK);

   always_comb begin
      dtype_in    = dtype_ff;
      dcnt_in     = dcnt_ff;
      code_in     = code_ff;
      last_in     = last_ff;
      fidx_in     = fidx_ff;
      glyph_in    = glyph_ff;
      tlen_in     = tlen_ff;
      vis_in      = vis_ff;
      rp_in       = rp_ff;
      sp_in       = sp_ff;
      tlong_in    = tlong_ff;
      fill_cnt_in = fill_cnt_ff;
      ch_in       = ch_ff;
      dp_in       = dp_ff;
      font_vld_in = font_vld_ff;
      srch_idx_in = srch_idx_ff;
      found_in    = found_ff;
      qfound_in   = qfound_ff;
      bitmap_in   = bitmap_ff;
      qbitmap_in  = qbitmap_ff;
      dl_in       = dl_ff;
      sl_in       = sl_ff;
      st_in       = st_ff;

      if (csr_we) begin
         case (csr_index)
            REG_DISPLAY_TYPE: dtype_in = csr_wdata[1:0];
            REG_DIGIT_COUNT:  dcnt_in  = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.load) begin
         code_in  = req_char_code;
         last_in  = req_end_of_text;
         fidx_in  = req_font_index;
         glyph_in = req_glyph_bits;
      end

      if (cmd.append && (code_ff != 21'd0)) begin
         if (room) begin
            tlen_in = tlen_ff + TLW'(1);
            if ((code_ff != CODE_DOT) && (vis_ff != VISIBLE_MAX)) begin
               vis_in = vis_ff + 6'd1;
            end
         end else if (code_ff != CODE_DOT) begin
            vis_in = VISIBLE_MAX;
         end
      end

      if (cmd.clear) begin
         tlen_in  = '0;
         vis_in   = '0;
         rp_in    = '0;
         sp_in    = '0;
         tlong_in = 1'b0;
      end

      if (cmd.font_wr && font_we) begin
         font_vld_in[font_waddr] = 1'b1;
      end

      if (cmd.fill_clr) begin
         fill_cnt_in = '0;
      end
      if (cmd.fill) begin
         fill_cnt_in = fill_cnt_ff + TLW'(1);
         if (sts.fill_last) begin
            tlen_in  = fill_n;
            vis_in   = 6'(fill_n);
            tlong_in = 1'b1;
         end
      end

      if (cmd.norm) begin
         if (int'(rp_ff) >= int'(tlen_ff)) begin
            rp_in = '0;
            sp_in = '0;
         end
         srch_idx_in = '0;
         found_in    = 1'b0;
         qfound_in   = 1'b0;
         bitmap_in   = GLYPH_BLANK;
         qbitmap_in  = GLYPH_BLANK;
      end

      if (cmd.skip && char_ok && (text_q_ff == CODE_DOT)) begin
         rp_in = RPW'(rp_next);
      end

      if (cmd.cap_ch) begin
         ch_in = char_ok ? text_q_ff : 21'd0;
      end
      if (cmd.cap_dp) begin
         dp_in = next_ok && (text_q_ff == CODE_DOT);
      end

      if (cmd.srch_step) begin
         srch_idx_in = srch_idx_ff + FAW'(1);
      end
      if (cmd.srch_eval && (f_code != 21'd0)) begin
         if (f_code == CODE_QMARK) begin
            qfound_in  = 1'b1;
            qbitmap_in = font_glyph_q_ff;
         end
         if (f_code == ch_ff) begin
            found_in  = 1'b1;
            bitmap_in = font_glyph_q_ff;
         end
      end

      if (cmd.emit) begin
         dl_in = {8{~don}};
         sl_in = {8{~son}};
         st_in = STATUS_NORMAL;
         if (cmd.emit_tick) begin
            if (dig_on) begin
               dl_in[pos[2:0]] = don;
            end
            for (int i = 0; i < 7; i++) begin
               sl_in[i] = ~(bm_sel[6-i] ^ son);
            end
            sl_in[7] = dp_ff ? son : ~son;
            if (tlong_ff) begin
               st_in = STATUS_DASHES;
            end else if (!found_ff) begin
               st_in = qfound_ff ? STATUS_QMARK : STATUS_BLANK;
            end
            sp_in = sp_ff + 4'd1;
            rp_in = RPW'(rp_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dtype_ff    <= 2'd0;
         dcnt_ff     <= DIGIT_COUNT_RESET;
         tlen_ff     <= '0;
         vis_ff      <= '0;
         rp_ff       <= '0;
         sp_ff       <= '0;
         tlong_ff    <= 1'b0;
         font_vld_ff <= '0;
      end else begin
         dtype_ff    <= dtype_in;
         dcnt_ff     <= dcnt_in;
         tlen_ff     <= tlen_in;
         vis_ff      <= vis_in;
         rp_ff       <= rp_in;
         sp_ff       <= sp_in;
         tlong_ff    <= tlong_in;
         font_vld_ff <= font_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      last_ff     <= last_in;
      fidx_ff     <= fidx_in;
      glyph_ff    <= glyph_in;
      fill_cnt_ff <= fill_cnt_in;
      ch_ff       <= ch_in;
      dp_ff       <= dp_in;
      srch_idx_ff <= srch_idx_in;
      eval_idx_ff <= srch_idx_ff;
      found_ff    <= found_in;
      qfound_ff   <= qfound_in;
      bitmap_ff   <= bitmap_in;
      qbitmap_ff  <= qbitmap_in;
      dl_ff       <= dl_in;
      sl_ff       <= sl_in;
      st_ff       <= st_in;
   end

   // text store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (text_we) begin
         text_mem[text_waddr] <= text_wdata;
      end
      text_q_ff <= text_mem[text_raddr];
   end

   // font tables, read at the search index every cycle
   always_ff @(posedge clock) begin
      if (font_we) begin
         font_code_mem[font_waddr]  <= code_ff;
         font_glyph_mem[font_waddr] <= glyph_ff;
      end
      font_code_q_ff  <= font_code_mem[srch_idx_ff];
      font_glyph_q_ff <= font_glyph_mem[srch_idx_ff];
      font_vld_q_ff   <= font_vld_ff[srch_idx_ff];
   end

   assign rsp_digit_lines   = dl_ff;
   assign rsp_segment_lines = sl_ff;
   assign rsp_status        = st_ff;

endmodule

// ===== design/sstx_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the seven-segment text scanner, bound to the top.
// Depends on seven_segment_text_scanner only through its ports.
module sstx_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // result beat lasts exactly one cycle
   a_beat_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // an accepted item keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted item did not raise busy");

   // no result while an item is still in progress
   a_beat_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while busy");

   // busy drops only together with a result beat
   a_busy_result: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("busy dropped without a result beat");

endmodule

bind seven_segment_text_scanner sstx_checker u_sstx_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
